@@ sv/ptl_pkg.sv @@
`timescale 1ns / 1ps

package ptl_pkg;

   // Font atlas geometry
   localparam int TILE_SIZE     = 8;
   localparam int ATLAS_COLUMNS = 16;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   localparam logic [7:0] SCALE_RESET     = 8'd16;
   localparam logic [4:0] ROW_PITCH_RESET = 5'd10;

   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_PITCH = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BEGIN = 2'd1,
      OP_CHAR  = 2'd2,
      OP_END   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_ACK    = 2'd0,
      KIND_GLYPH  = 2'd1,
      KIND_REPORT = 2'd2
   } kind_type;

endpackage

@@ sv/proportional_text_layout.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_*     in         req_valid/req_stall  opcode, code, glyph_width, start_x, start_y, color
// rsp_*     out        rsp_valid/rsp_stall  kind, draw_x/y, src_x/y, draw_size, draw_color,
//                                           text_width
// csr_*     in         csr_write            csr_index, csr_wdata (scale, row pitch)
//
// Every item yields exactly one result; after acceptance it passes the
// table-read stage and then the result register, which drives rsp.
// One item per cycle sustained unless rsp stalls: the width table read and the
// cursor update (small multiplies and a 25-bit add with saturation) each take one stage.
// Synchronous active-high reset clears control, cursor and line state, sets the
// config registers to defaults; the width table is not cleared and must be loaded first.
// A stall on rsp holds the result register and the stage before it; req_stall
// rises only when both are full and rsp is stalled.

module proportional_text_layout (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_opcode,
   input  logic [7:0]                        req_code,
   input  logic [3:0]                        req_glyph_width,
   input  logic signed [15:0]                req_start_x,
   input  logic signed [15:0]                req_start_y,
   input  logic [31:0]                       req_color,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic signed [11:0]                rsp_draw_x,
   output logic signed [11:0]                rsp_draw_y,
   output logic [6:0]                        rsp_src_x,
   output logic [6:0]                        rsp_src_y,
   output logic [10:0]                       rsp_draw_size,
   output logic [31:0]                       rsp_draw_color,
   output logic [15:0]                       rsp_text_width,
   // configuration
   input  logic                              csr_write,
   input  logic [ptl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ptl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic signed [23:0] CUR_MAX = 24'sh7FFFFF;

   // floor((c + 8) / 16), clamped to 12-bit signed
   function automatic logic signed [11:0] round_pix(input logic signed [23:0] c);
      logic signed [24:0] v;
      logic signed [20:0] p;
      v = {c[23], c} + 25'sd8;
      p = v[24:4];
      if (p > 21'sd2047)
         return 12'sd2047;
      else if (p < -21'sd2048)
         return -12'sd2048;
      else
         return p[11:0];
   endfunction

   // configuration registers
   logic [7:0] scale_q4_ff;
   logic [4:0] row_pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_q4_ff  <= ptl_pkg::SCALE_RESET;
         row_pitch_ff <= ptl_pkg::ROW_PITCH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ptl_pkg::CSR_SCALE:     scale_q4_ff  <= csr_wdata[7:0];
            ptl_pkg::CSR_ROW_PITCH: row_pitch_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // handshake: stage 1 (table read) and result register
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic req_accept;
   logic s2_adv;

   assign req_stall  = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign s2_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall)
            s1_valid_ff <= req_valid;
         if (!rsp_valid_ff || !rsp_stall)
            rsp_valid_ff <= s1_valid_ff;
      end
   end

   // width table: write on accept of a load, read on accept of any item.
   // A load followed directly by a character of the same code sees the new
   // entry, since the write lands at the edge before the read.
   logic [3:0]               width_mem [256];
   logic [3:0]               s1_width_ff;
   ptl_pkg::opcode_type      s1_op_ff;
   logic [7:0]               s1_code_ff;
   logic signed [15:0]       s1_start_x_ff;
   logic signed [15:0]       s1_start_y_ff;
   logic [31:0]              s1_color_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (ptl_pkg::opcode_type'(req_opcode) == ptl_pkg::OP_LOAD)
            width_mem[req_code] <= req_glyph_width;
         s1_width_ff   <= width_mem[req_code];
         s1_op_ff      <= ptl_pkg::opcode_type'(req_opcode);
         s1_code_ff    <= req_code;
         s1_start_x_ff <= req_start_x;
         s1_start_y_ff <= req_start_y;
         s1_color_ff   <= req_color;
      end
   end

   // layout state
   logic signed [23:0] cursor_x_ff, cursor_x_in;
   logic signed [23:0] cursor_y_ff, cursor_y_in;
   logic signed [15:0] origin_x_ff, origin_x_in;
   logic [31:0]        held_color_ff, held_color_in;
   logic [15:0]        line_len_ff, line_len_in;
   logic [15:0]        max_len_ff, max_len_in;

   // result register
   ptl_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic signed [11:0] rsp_draw_x_ff, rsp_draw_x_in;
   logic signed [11:0] rsp_draw_y_ff, rsp_draw_y_in;
   logic [6:0]         rsp_src_x_ff, rsp_src_x_in;
   logic [6:0]         rsp_src_y_ff, rsp_src_y_in;
   logic [10:0]        rsp_draw_size_ff, rsp_draw_size_in;
   logic [31:0]        rsp_draw_color_ff, rsp_draw_color_in;
   logic [15:0]        rsp_text_width_ff, rsp_text_width_in;

   // datapath terms
   logic [11:0]        adv_x;
   logic [12:0]        step_y;
   logic signed [24:0] sum_x;
   logic signed [24:0] sum_y;
   logic signed [23:0] next_x;
   logic signed [23:0] next_y;
   logic [16:0]        len_sum;
   logic [15:0]        longest;
   logic [11:0]        src_x_full;
   logic [11:0]        src_y_full;
   logic [11:0]        size_full;

   always_comb begin
      adv_x  = 12'(s1_width_ff) * 12'(scale_q4_ff);
      step_y = 13'(row_pitch_ff) * 13'(scale_q4_ff);

      // both steps are non-negative, so only the upper bound can be crossed
      sum_x  = {cursor_x_ff[23], cursor_x_ff} + $signed({13'b0, adv_x});
      sum_y  = {cursor_y_ff[23], cursor_y_ff} + $signed({12'b0, step_y});
      next_x = (!sum_x[24] && sum_x[23]) ? CUR_MAX : sum_x[23:0];
      next_y = (!sum_y[24] && sum_y[23]) ? CUR_MAX : sum_y[23:0];

      len_sum = {1'b0, line_len_ff} + 17'(s1_width_ff);
      longest = (line_len_ff > max_len_ff) ? line_len_ff : max_len_ff;

      src_x_full = 12'(s1_code_ff % ptl_pkg::ATLAS_COLUMNS) * 12'(ptl_pkg::TILE_SIZE);
      src_y_full = 12'(s1_code_ff / ptl_pkg::ATLAS_COLUMNS) * 12'(ptl_pkg::TILE_SIZE);
      size_full  = 12'(ptl_pkg::TILE_SIZE) * 12'(scale_q4_ff);
   end

   always_comb begin
      // hold state unless an item below says otherwise
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      origin_x_in   = origin_x_ff;
      held_color_in = held_color_ff;
      line_len_in   = line_len_ff;
      max_len_in    = max_len_ff;

      // unused result fields stay zero
      rsp_kind_in       = ptl_pkg::KIND_ACK;
      rsp_draw_x_in     = '0;
      rsp_draw_y_in     = '0;
      rsp_src_x_in      = '0;
      rsp_src_y_in      = '0;
      rsp_draw_size_in  = '0;
      rsp_draw_color_in = '0;
      rsp_text_width_in = '0;

      case (s1_op_ff)
         ptl_pkg::OP_LOAD: ;  // table already written; acknowledge only
         ptl_pkg::OP_BEGIN: begin
            cursor_x_in   = 24'(s1_start_x_ff);
            cursor_y_in   = 24'(s1_start_y_ff);
            origin_x_in   = s1_start_x_ff;
            held_color_in = s1_color_ff;
            line_len_in   = '0;
            max_len_in    = '0;
         end
         ptl_pkg::OP_CHAR: begin
            if (s1_code_ff == ptl_pkg::NEWLINE_CODE) begin
               // return to origin, step down, fold the finished line
               cursor_x_in = 24'(origin_x_ff);
               cursor_y_in = next_y;
               max_len_in  = longest;
               line_len_in = '0;
            end else begin
               rsp_kind_in       = ptl_pkg::KIND_GLYPH;
               rsp_draw_x_in     = round_pix(cursor_x_ff);
               rsp_draw_y_in     = round_pix(cursor_y_ff);
               rsp_src_x_in      = (src_x_full > 12'd127) ? 7'd127 : src_x_full[6:0];
               rsp_src_y_in      = (src_y_full > 12'd127) ? 7'd127 : src_y_full[6:0];
               rsp_draw_size_in  = (size_full > 12'd2047) ? 11'd2047 : size_full[10:0];
               rsp_draw_color_in = held_color_ff;
               cursor_x_in       = next_x;
               line_len_in       = len_sum[16] ? 16'hFFFF : len_sum[15:0];
            end
         end
         ptl_pkg::OP_END: begin
            rsp_kind_in       = ptl_pkg::KIND_REPORT;
            rsp_text_width_in = longest;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         origin_x_ff   <= '0;
         held_color_ff <= '0;
         line_len_ff   <= '0;
         max_len_ff    <= '0;
      end else if (s2_adv) begin
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         origin_x_ff   <= origin_x_in;
         held_color_ff <= held_color_in;
         line_len_ff   <= line_len_in;
         max_len_ff    <= max_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_kind_ff       <= rsp_kind_in;
         rsp_draw_x_ff     <= rsp_draw_x_in;
         rsp_draw_y_ff     <= rsp_draw_y_in;
         rsp_src_x_ff      <= rsp_src_x_in;
         rsp_src_y_ff      <= rsp_src_y_in;
         rsp_draw_size_ff  <= rsp_draw_size_in;
         rsp_draw_color_ff <= rsp_draw_color_in;
         rsp_text_width_ff <= rsp_text_width_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_draw_x     = rsp_draw_x_ff;
   assign rsp_draw_y     = rsp_draw_y_ff;
   assign rsp_src_x      = rsp_src_x_ff;
   assign rsp_src_y      = rsp_src_y_ff;
   assign rsp_draw_size  = rsp_draw_size_ff;
   assign rsp_draw_color = rsp_draw_color_ff;
   assign rsp_text_width = rsp_text_width_ff;

endmodule

@@ sv/ptl_checker.sv @@
`timescale 1ns / 1ps

module ptl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_kind,
   input logic signed [11:0]              rsp_draw_x,
   input logic signed [11:0]              rsp_draw_y,
   input logic [6:0]                      rsp_src_x,
   input logic [6:0]                      rsp_src_y,
   input logic [10:0]                     rsp_draw_size,
   input logic [31:0]                     rsp_draw_color,
   input logic [15:0]                     rsp_text_width
);

   // no result is left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == ptl_pkg::KIND_ACK) |->
         (rsp_draw_x == 0 && rsp_draw_y == 0 && rsp_src_x == 0 && rsp_src_y == 0 &&
          rsp_draw_size == 0 && rsp_draw_color == 0 && rsp_text_width == 0))
      else $error("acknowledge carries nonzero fields");

   a_glyph_no_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == ptl_pkg::KIND_GLYPH) |-> rsp_text_width == 0)
      else $error("placement carries a width report");

   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == ptl_pkg::KIND_REPORT) |->
         (rsp_draw_x == 0 && rsp_draw_y == 0 && rsp_src_x == 0 && rsp_src_y == 0 &&
          rsp_draw_size == 0 && rsp_draw_color == 0))
      else $error("width report carries placement fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_draw_x) &&
          $stable(rsp_text_width)))
      else $error("stalled result changed");

endmodule

bind proportional_text_layout ptl_checker u_ptl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_draw_x     (rsp_draw_x),
   .rsp_draw_y     (rsp_draw_y),
   .rsp_src_x      (rsp_src_x),
   .rsp_src_y      (rsp_src_y),
   .rsp_draw_size  (rsp_draw_size),
   .rsp_draw_color (rsp_draw_color),
   .rsp_text_width (rsp_text_width)
);
